// ===== hw/rtl/tkmd_pkg.sv =====
// ----------------------------------------------------------------------------
// tkmd_pkg
// shared types, codes and constants of the console key and pointer decoder
// ----------------------------------------------------------------------------
package tkmd_pkg;

  localparam int unsigned ByteBits = 8;
  localparam int unsigned TermBits = 10;
  localparam int unsigned PosBits  = 9;

  localparam int unsigned PanelWidthDef  = 480;
  localparam int unsigned PanelHeightDef = 272;
  localparam int unsigned AccBitsDef     = 12;
  localparam int unsigned AccBitsMax     = 16;

  localparam logic [TermBits-1:0] TermColsReset = 10'd80;
  localparam logic [TermBits-1:0] TermRowsReset = 10'd24;

  // queue depths
  localparam int unsigned CmdDepth = 4;
  localparam int unsigned ResDepth = 4;

  // console characters
  localparam logic [ByteBits-1:0] ChEsc        = 8'h1B;
  localparam logic [ByteBits-1:0] ChLbrack     = 8'h5B;
  localparam logic [ByteBits-1:0] ChLess       = 8'h3C;
  localparam logic [ByteBits-1:0] ChSemi       = 8'h3B;
  localparam logic [ByteBits-1:0] ChZero       = 8'h30;
  localparam logic [ByteBits-1:0] ChNine       = 8'h39;
  localparam logic [ByteBits-1:0] ChUpperA     = 8'h41;
  localparam logic [ByteBits-1:0] ChUpperD     = 8'h44;
  localparam logic [ByteBits-1:0] ChRelease    = 8'h6D;
  localparam logic [ByteBits-1:0] KeyArrowBase = 8'd128;
  localparam logic [ByteBits-1:0] KeyNone      = 8'd0;

  typedef enum logic [0:0] {
    RegTermCols = 1'b0,
    RegTermRows = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    EvKey     = 3'd0,
    EvPress   = 3'd1,
    EvDrag    = 3'd2,
    EvRelease = 3'd3,
    EvRight   = 3'd4
  } event_kind_e;

  // classified work handed from front to back
  typedef struct packed {
    logic                  is_mouse;
    logic                  two_keys;
    logic [ByteBits-1:0]   key_a;
    logic [ByteBits-1:0]   key_b;
    event_kind_e           kind;
    logic [AccBitsMax-1:0] cx;
    logic [AccBitsMax-1:0] cy;
  } cmd_t;

  typedef struct packed {
    event_kind_e         kind;
    logic [ByteBits-1:0] key;
    logic [PosBits-1:0]  pos_x;
    logic [PosBits-1:0]  pos_y;
    logic                last;
  } res_t;

endpackage

// ===== hw/rtl/tkmd_fifo.sv =====
// ----------------------------------------------------------------------------
// tkmd_fifo
// small flop based first-in first-out queue
// ----------------------------------------------------------------------------
module tkmd_fifo import tkmd_pkg::*; #(
  parameter int unsigned Width = $bits(res_t),
  parameter int unsigned Depth = ResDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CntBits'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/tkmd_front.sv =====
// ----------------------------------------------------------------------------
// tkmd_front
// byte parser: escape sequences, csi skipping, sgr mouse field collection
// ----------------------------------------------------------------------------
module tkmd_front import tkmd_pkg::*; #(
  parameter int unsigned ACC_BITS = AccBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [ByteBits-1:0] rx_byte_i,
  output logic                cmd_push_o,
  output cmd_t                cmd_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StEsc   = 5'b00010,
    StCsi   = 5'b00100,
    StSkip  = 5'b01000,
    StMouse = 5'b10000
  } front_state_e;

  front_state_e        state_q, state_d;
  logic [1:0]          field_q, field_d;
  logic [ACC_BITS-1:0] btn_q, btn_d, col_q, col_d, row_q, row_d;
  logic [ACC_BITS-1:0] cx, cy;
  logic                is_digit, is_param, btn_big;
  event_kind_e         mouse_kind;

  // decimal shift-in with saturation
  function automatic logic [ACC_BITS-1:0] acc_push(input logic [ACC_BITS-1:0] acc,
                                                   input logic [3:0] dig);
    logic [ACC_BITS+3:0] v;
    v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (ACC_BITS + 4)'(dig);
    if (|v[ACC_BITS+3:ACC_BITS]) begin
      return '1;
    end
    return v[ACC_BITS-1:0];
  endfunction

  assign is_digit = (rx_byte_i inside {[ChZero:ChNine]});
  assign is_param = is_digit || (rx_byte_i == ChSemi);
  assign btn_big  = |btn_q[ACC_BITS-1:6];
  assign cx       = (col_q == '0) ? '0 : col_q - 1'b1;
  assign cy       = (row_q == '0) ? '0 : row_q - 1'b1;

  always_comb begin
    if (rx_byte_i == ChRelease) begin
      mouse_kind = EvRelease;
    end else if (btn_q[1:0] == 2'b10) begin
      mouse_kind = EvRight;
    end else if (btn_q[5]) begin
      mouse_kind = EvDrag;
    end else begin
      mouse_kind = EvPress;
    end
  end

  always_comb begin
    state_d        = state_q;
    field_d        = field_q;
    btn_d          = btn_q;
    col_d          = col_q;
    row_d          = row_q;
    cmd_push_o     = 1'b0;
    cmd_o.is_mouse = 1'b0;
    cmd_o.two_keys = 1'b0;
    cmd_o.key_a    = rx_byte_i;
    cmd_o.key_b    = rx_byte_i;
    cmd_o.kind     = EvKey;
    cmd_o.cx       = AccBitsMax'(cx);
    cmd_o.cy       = AccBitsMax'(cy);
    if (accept_i) begin
      case (state_q)
        StEsc: begin
          if (rx_byte_i == ChLbrack) begin
            state_d = StCsi;
          end else if (rx_byte_i == ChEsc) begin
            // lone escape key, the new escape opens a fresh sequence
            cmd_push_o  = 1'b1;
            cmd_o.key_a = ChEsc;
          end else begin
            cmd_push_o     = 1'b1;
            cmd_o.two_keys = 1'b1;
            cmd_o.key_a    = ChEsc;
            state_d        = StIdle;
          end
        end
        StCsi: begin
          if (rx_byte_i == ChLess) begin
            state_d = StMouse;
            field_d = '0;
            btn_d   = '0;
            col_d   = '0;
            row_d   = '0;
          end else if (rx_byte_i inside {[ChUpperA:ChUpperD]}) begin
            cmd_push_o  = 1'b1;
            cmd_o.key_a = KeyArrowBase + (rx_byte_i - ChUpperA);
            state_d     = StIdle;
          end else if (is_param) begin
            state_d = StSkip;
          end else begin
            state_d = StIdle;
          end
        end
        StSkip: begin
          if (!is_param) begin
            state_d = StIdle;
          end
        end
        StMouse: begin
          if (is_digit) begin
            case (field_q)
              2'd0:    btn_d = acc_push(btn_q, rx_byte_i[3:0]);
              2'd1:    col_d = acc_push(col_q, rx_byte_i[3:0]);
              2'd2:    row_d = acc_push(row_q, rx_byte_i[3:0]);
              default: ;
            endcase
          end else if (rx_byte_i == ChSemi) begin
            if (field_q != 2'd3) begin
              field_d = field_q + 1'b1;
            end
          end else begin
            state_d = StIdle;
            // wheel and extra buttons give nothing
            if (!btn_big) begin
              cmd_push_o     = 1'b1;
              cmd_o.is_mouse = 1'b1;
              cmd_o.kind     = mouse_kind;
            end
          end
        end
        default: begin
          if (rx_byte_i == ChEsc) begin
            state_d = StEsc;
          end else begin
            state_d    = StIdle;
            cmd_push_o = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      field_q <= '0;
      btn_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      field_q <= field_d;
      btn_q   <= btn_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

endmodule

// ===== hw/rtl/tkmd_back.sv =====
// ----------------------------------------------------------------------------
// tkmd_back
// result builder: key items and cell to panel mapping by shift-subtract
// ----------------------------------------------------------------------------
module tkmd_back import tkmd_pkg::*; #(
  parameter int unsigned PANEL_WIDTH  = PanelWidthDef,
  parameter int unsigned PANEL_HEIGHT = PanelHeightDef,
  parameter int unsigned ACC_BITS     = AccBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [TermBits-1:0] term_cols_i,
  input  logic [TermBits-1:0] term_rows_i,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                cmd_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output res_t                res_o
);

  localparam int unsigned DimMax   = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
  localparam int unsigned DimBits  = $clog2(DimMax + 1);
  localparam int unsigned QuotBits = $clog2(DimMax);
  localparam int unsigned CntBits  = $clog2(QuotBits + 1);
  localparam int unsigned ProdBits = ((ACC_BITS > TermBits) ? ACC_BITS : TermBits) + DimBits;

  typedef enum logic [6:0] {
    BkIdle = 7'b0000001,
    BkKey1 = 7'b0000010,
    BkKey2 = 7'b0000100,
    BkMul  = 7'b0001000,
    BkCmp  = 7'b0010000,
    BkDiv  = 7'b0100000,
    BkOut  = 7'b1000000
  } back_state_e;

  back_state_e         state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [ProdBits-1:0] rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  logic [ProdBits-1:0] lim_x_q, lim_y_q;
  logic [ProdBits-1:0] sub_x, sub_y;
  logic [QuotBits-1:0] qx_q, qx_d, qy_q, qy_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                ovf_x_q, ovf_x_d, ovf_y_q, ovf_y_d;
  logic                bit_x, bit_y;
  logic [PosBits-1:0]  held_x_q, held_x_d, held_y_q, held_y_d;
  logic [TermBits-1:0] cols_eff, rows_eff;
  logic [DimBits-1:0]  px_full, py_full;

  assign cols_eff = (term_cols_i == '0) ? TermBits'(1) : term_cols_i;
  assign rows_eff = (term_rows_i == '0) ? TermBits'(1) : term_rows_i;

  // one divisor-shift step per cycle on each axis
  assign sub_x = ProdBits'(cols_eff) << cnt_q;
  assign sub_y = ProdBits'(rows_eff) << cnt_q;
  assign bit_x = (rem_x_q >= sub_x);
  assign bit_y = (rem_y_q >= sub_y);

  assign px_full = ovf_x_q ? DimBits'(PANEL_WIDTH - 1) : DimBits'(qx_q);
  assign py_full = ovf_y_q ? '0 : DimBits'(PANEL_HEIGHT - 1) - DimBits'(qy_q);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    rem_x_d     = rem_x_q;
    rem_y_d     = rem_y_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    cnt_d       = cnt_q;
    ovf_x_d     = ovf_x_q;
    ovf_y_d     = ovf_y_q;
    held_x_d    = held_x_q;
    held_y_d    = held_y_q;
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    res_o.kind  = EvKey;
    res_o.key   = cmd_q.key_a;
    res_o.pos_x = held_x_q;
    res_o.pos_y = held_y_q;
    res_o.last  = 1'b1;
    case (state_q)
      BkIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          state_d   = cmd_i.is_mouse ? BkMul : BkKey1;
        end
      end
      BkKey1: begin
        res_o.last = !cmd_q.two_keys;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = cmd_q.two_keys ? BkKey2 : BkIdle;
        end
      end
      BkKey2: begin
        res_o.key = cmd_q.key_b;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = BkIdle;
        end
      end
      BkMul: begin
        rem_x_d = ProdBits'(cmd_q.cx[ACC_BITS-1:0]) * ProdBits'(PANEL_WIDTH);
        rem_y_d = ProdBits'(cmd_q.cy[ACC_BITS-1:0]) * ProdBits'(PANEL_HEIGHT);
        state_d = BkCmp;
      end
      BkCmp: begin
        // quotient would reach the panel size: clamp instead
        ovf_x_d = (rem_x_q >= lim_x_q);
        ovf_y_d = (rem_y_q >= lim_y_q);
        qx_d    = '0;
        qy_d    = '0;
        cnt_d   = CntBits'(QuotBits - 1);
        state_d = BkDiv;
      end
      BkDiv: begin
        rem_x_d = bit_x ? rem_x_q - sub_x : rem_x_q;
        rem_y_d = bit_y ? rem_y_q - sub_y : rem_y_q;
        qx_d    = QuotBits'({qx_q, bit_x});
        qy_d    = QuotBits'({qy_q, bit_y});
        if (cnt_q == '0) begin
          state_d = BkOut;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      BkOut: begin
        res_o.kind  = cmd_q.kind;
        res_o.key   = KeyNone;
        res_o.pos_x = PosBits'(px_full);
        res_o.pos_y = PosBits'(py_full);
        if (!res_full_i) begin
          res_push_o = 1'b1;
          held_x_d   = PosBits'(px_full);
          held_y_d   = PosBits'(py_full);
          state_d    = BkIdle;
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BkIdle;
      held_x_q <= '0;
      held_y_q <= '0;
    end else begin
      state_q  <= state_d;
      held_x_q <= held_x_d;
      held_y_q <= held_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    rem_x_q <= rem_x_d;
    rem_y_q <= rem_y_d;
    qx_q    <= qx_d;
    qy_q    <= qy_d;
    cnt_q   <= cnt_d;
    ovf_x_q <= ovf_x_d;
    ovf_y_q <= ovf_y_d;
    // clamp limits follow the geometry registers
    lim_x_q <= ProdBits'(cols_eff) * ProdBits'(PANEL_WIDTH);
    lim_y_q <= ProdBits'(rows_eff) * ProdBits'(PANEL_HEIGHT);
  end

endmodule

// ===== hw/rtl/terminal_key_mouse_decoder.sv =====
// ----------------------------------------------------------------------------
// terminal_key_mouse_decoder
// console byte stream to key and pointer items
// ----------------------------------------------------------------------------
// Bytes go in through push/full, one per cycle while the command queue has
// room; items come out through empty/pop, oldest first. A plain byte gives one
// key item, ESC [ A..D an arrow key 128..131, ESC and anything but [ or ESC
// gives key 27 followed by the byte, and an SGR mouse report ESC [ < b;x;y M/m
// gives one pointer item, none for wheel or extra buttons, with the cell mapped
// onto the panel (x clamped to the panel width, y counted upwards). Other CSI
// sequences give nothing. Key items carry the position of the latest pointer
// item. The front parser takes a byte every cycle while the command queue has
// room; the back end takes a new command only when done with the last, and maps
// a pointer item by multiply, compare and its one-bit-per-cycle shift-subtract
// divider. term_cols and term_rows are written through the cfg channel, which
// is always ready; write them only while no item is in flight.
// ----------------------------------------------------------------------------
module terminal_key_mouse_decoder import tkmd_pkg::*; #(
  parameter int unsigned PANEL_WIDTH  = PanelWidthDef,
  parameter int unsigned PANEL_HEIGHT = PanelHeightDef,
  parameter int unsigned ACC_BITS     = AccBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_index_i,
  input  logic [TermBits-1:0] cfg_data_i,
  // console bytes
  input  logic                push,
  output logic                full,
  input  logic [ByteBits-1:0] rx_byte_i,
  // decoded items
  output logic                empty,
  input  logic                pop,
  output logic [2:0]          event_kind_o,
  output logic [ByteBits-1:0] key_code_o,
  output logic [PosBits-1:0]  pos_x_o,
  output logic [PosBits-1:0]  pos_y_o,
  output logic                last_of_run_o
);

  logic [TermBits-1:0] term_cols_q, term_rows_q;
  logic                accept;
  logic                cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t                cmd_in, cmd_head;
  logic                res_push, res_full;
  res_t                res_in, res_head;

  // geometry registers, the channel never stalls
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_cols_q <= TermColsReset;
      term_rows_q <= TermRowsReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegTermCols: term_cols_q <= cfg_data_i;
        RegTermRows: term_rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // every byte makes at most one command, so queue room is all the front needs
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  tkmd_front #(
    .ACC_BITS (ACC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // decouples the parser from the mapping unit
  tkmd_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  tkmd_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .ACC_BITS     (ACC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .term_cols_i (term_cols_q),
    .term_rows_i (term_rows_q),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // finished items wait here for the consumer
  tkmd_fifo #(
    .Width ($bits(res_t)),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty)
  );

  assign event_kind_o  = res_head.kind;
  assign key_code_o    = res_head.key;
  assign pos_x_o       = res_head.pos_x;
  assign pos_y_o       = res_head.pos_y;
  assign last_of_run_o = res_head.last;

endmodule

// ===== hw/rtl/tkmd_checker.sv =====
// ----------------------------------------------------------------------------
// tkmd_checker
// port level checks of the console decoder, bound to the top level
// ----------------------------------------------------------------------------
module tkmd_checker import tkmd_pkg::*; #(
  parameter int unsigned PANEL_WIDTH  = PanelWidthDef,
  parameter int unsigned PANEL_HEIGHT = PanelHeightDef
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input logic [2:0]          event_kind_o,
  input logic [ByteBits-1:0] key_code_o,
  input logic [PosBits-1:0]  pos_x_o,
  input logic [PosBits-1:0]  pos_y_o,
  input logic                last_of_run_o
);

  // pointer items carry no character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && event_kind_o != EvKey) |-> key_code_o == KeyNone)
    else $error("pointer item with non-zero key code");

  // a pointer item is always the only item of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && event_kind_o != EvKey) |-> last_of_run_o)
    else $error("pointer item not marked last");

  // mapped positions stay on the panel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (32'(pos_x_o) < PANEL_WIDTH && 32'(pos_y_o) < PANEL_HEIGHT))
    else $error("position off the panel");

  // a waiting item holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(event_kind_o) && $stable(key_code_o)
                          && $stable(pos_x_o) && $stable(pos_y_o)
                          && $stable(last_of_run_o)))
    else $error("waiting item changed");

endmodule

bind terminal_key_mouse_decoder tkmd_checker #(
  .PANEL_WIDTH  (PANEL_WIDTH),
  .PANEL_HEIGHT (PANEL_HEIGHT)
) u_tkmd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .event_kind_o  (event_kind_o),
  .key_code_o    (key_code_o),
  .pos_x_o       (pos_x_o),
  .pos_y_o       (pos_y_o),
  .last_of_run_o (last_of_run_o)
);
